// ===== sv/igu_pkg.sv =====
// Shared types and fixed field widths for the Ising Glauber spin update block.
// No dependencies; every other file of the block imports this package.
package igu_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned PIDX_W  = 5;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned MAXN_W  = 4;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [MAXN_W-1:0] MAXN_RESET = 4'd4;

  // Register index, taken from the word address of the APB port.
  localparam logic [PADDR_W-3:0] REG_MAX_NEIGH = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_SPIN   = 3'd0,
    KIND_LOAD_NEIGH  = 3'd1,
    KIND_LOAD_COUNT  = 3'd2,
    KIND_LOAD_TABLE  = 3'd3,
    KIND_UPDATE      = 3'd4,
    KIND_READ_SPIN   = 3'd5,
    KIND_CLEAR_COUNT = 3'd6
  } kind_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  typedef struct packed {
    mem_cmd_t spin;
    mem_cmd_t neigh;
    mem_cmd_t count;
    mem_cmd_t tbl;
  } store_cmd_t;

endpackage

// ===== sv/igu_item_if.sv =====
// Input channel of the spin update block: valid/ready handshake and item fields.
// Depends on igu_pkg for the field widths.
interface igu_item_if;
  import igu_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    spin_index;
  logic [SLOT_W-1:0]   neigh_slot;
  logic [IDX_W-1:0]    neighbour_index;
  logic [CNT_W-1:0]    neighbour_count;
  logic                spin_value;
  logic [PIDX_W-1:0]   prob_index;
  logic [PROB_W-1:0]   accept_prob;
  logic [PROB_W-1:0]   random_fraction;

  modport source (
    output valid, kind, spin_index, neigh_slot, neighbour_index, neighbour_count,
           spin_value, prob_index, accept_prob, random_fraction,
    input  ready
  );

  modport sink (
    input  valid, kind, spin_index, neigh_slot, neighbour_index, neighbour_count,
           spin_value, prob_index, accept_prob, random_fraction,
    output ready
  );
endinterface

// ===== sv/igu_result_if.sv =====
// Result channel of the spin update block: valid/ready handshake and result fields.
// Depends on igu_pkg for the field widths.
interface igu_result_if;
  import igu_pkg::*;

  logic               valid;
  logic               ready;
  logic               spin_state;
  logic               flipped;
  logic [TOTAL_W-1:0] accepted_total;

  modport source (
    output valid, spin_state, flipped, accepted_total,
    input  ready
  );

  modport sink (
    input  valid, spin_state, flipped, accepted_total,
    output ready
  );
endinterface

// ===== sv/igu_modred.sv =====
// Pipelined reduction of a 12-bit lattice index modulo MAX_SPINS.
// Depends on igu_pkg; one compare-and-subtract per stage, at least one stage.
module igu_modred #(
  parameter int unsigned MAX_SPINS = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [igu_pkg::IDX_W-1:0] value_i,
  output logic                     valid_o,
  output logic [igu_pkg::IDX_W-1:0] value_o
);
  import igu_pkg::*;

  localparam int unsigned RANGE     = 1 << IDX_W;
  localparam bit          IS_POW2   = (MAX_SPINS & (MAX_SPINS - 1)) == 0;
  localparam int          SUB_STEPS = (IS_POW2 || MAX_SPINS >= RANGE) ? 0 :
                                      (IDX_W - $clog2(MAX_SPINS) + 1);
  localparam int          STAGES    = (SUB_STEPS > 0) ? SUB_STEPS : 1;
  localparam logic [IDX_W-1:0] KEEP_MASK = (IS_POW2 && MAX_SPINS < RANGE) ?
                                           IDX_W'(MAX_SPINS - 1) : {IDX_W{1'b1}};

  logic [IDX_W-1:0] val_q [STAGES];
  logic [STAGES-1:0] vld_q;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    // Largest multiple of the modulus first, so each stage removes one binary digit.
    localparam int          SHIFT = SUB_STEPS - 1 - g;
    localparam int          SUBV  = (SUB_STEPS > 0) ? (MAX_SPINS << SHIFT) : 0;
    localparam logic [IDX_W:0] SUB = (IDX_W + 1)'(SUBV);

    logic [IDX_W-1:0] stage_in;
    logic             stage_vld;

    if (g == 0) begin : g_first
      assign stage_in  = value_i & KEEP_MASK;
      assign stage_vld = valid_i;
    end else begin : g_next
      assign stage_in  = val_q[g-1];
      assign stage_vld = vld_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if ({1'b0, stage_in} >= SUB) begin
        val_q[g] <= stage_in - SUB[IDX_W-1:0];
      end else begin
        val_q[g] <= stage_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= stage_vld;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign value_o = val_q[STAGES-1];

endmodule

// ===== sv/igu_store.sv =====
// Synchronous single-port memories for spins, neighbour lists, counts and the table.
// Depends on igu_pkg for the command struct; read data is registered.
module igu_store #(
  parameter int unsigned MAX_SPINS = 4096,
  parameter int unsigned MAX_NEIGH = 8
) (
  input  logic                                        clk_i,
  input  igu_pkg::store_cmd_t                         cmd_i,
  input  logic [$clog2(MAX_SPINS)-1:0]                spin_addr_i,
  input  logic                                        spin_wdata_i,
  output logic                                        spin_rdata_o,
  input  logic [$clog2(MAX_SPINS*MAX_NEIGH)-1:0]      neigh_addr_i,
  input  logic [igu_pkg::IDX_W-1:0]                   neigh_wdata_i,
  output logic [igu_pkg::IDX_W-1:0]                   neigh_rdata_o,
  input  logic [$clog2(MAX_SPINS)-1:0]                count_addr_i,
  input  logic [igu_pkg::CNT_W-1:0]                   count_wdata_i,
  output logic [igu_pkg::CNT_W-1:0]                   count_rdata_o,
  input  logic [$clog2(2*MAX_NEIGH+1)-1:0]            tbl_addr_i,
  input  logic [igu_pkg::PROB_W-1:0]                  tbl_wdata_i,
  output logic [igu_pkg::PROB_W-1:0]                  tbl_rdata_o
);
  import igu_pkg::*;

  localparam int unsigned TL = 2 * MAX_NEIGH + 1;

  logic              spin_mem  [MAX_SPINS];
  logic [IDX_W-1:0]  neigh_mem [MAX_SPINS*MAX_NEIGH];
  logic [CNT_W-1:0]  count_mem [MAX_SPINS];
  logic [PROB_W-1:0] tbl_mem   [TL];

  logic              spin_rdata_q;
  logic [IDX_W-1:0]  neigh_rdata_q;
  logic [CNT_W-1:0]  count_rdata_q;
  logic [PROB_W-1:0] tbl_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.spin.wr) begin
      spin_mem[spin_addr_i] <= spin_wdata_i;
    end
    if (cmd_i.spin.rd) begin
      spin_rdata_q <= spin_mem[spin_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.neigh.wr) begin
      neigh_mem[neigh_addr_i] <= neigh_wdata_i;
    end
    if (cmd_i.neigh.rd) begin
      neigh_rdata_q <= neigh_mem[neigh_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.count.wr) begin
      count_mem[count_addr_i] <= count_wdata_i;
    end
    if (cmd_i.count.rd) begin
      count_rdata_q <= count_mem[count_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl.wr) begin
      tbl_mem[tbl_addr_i] <= tbl_wdata_i;
    end
    if (cmd_i.tbl.rd) begin
      tbl_rdata_q <= tbl_mem[tbl_addr_i];
    end
  end

  assign spin_rdata_o  = spin_rdata_q;
  assign neigh_rdata_o = neigh_rdata_q;
  assign count_rdata_o = count_rdata_q;
  assign tbl_rdata_o   = tbl_rdata_q;

endmodule

// ===== sv/igu_ctrl.sv =====
// Item sequencer: decodes items, walks the neighbour list and applies the flip.
// Depends on igu_pkg and the two channel interfaces; drives igu_store and igu_modred.
module igu_ctrl #(
  parameter int unsigned MAX_SPINS = 4096,
  parameter int unsigned MAX_NEIGH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [igu_pkg::MAXN_W-1:0]             max_neighbours_i,
  igu_item_if.sink                               item_i,
  igu_result_if.source                           result_o,
  output logic                                   red_valid_o,
  output logic [igu_pkg::IDX_W-1:0]              red_value_o,
  input  logic                                   red_valid_i,
  input  logic [igu_pkg::IDX_W-1:0]              red_value_i,
  output igu_pkg::store_cmd_t                    cmd_o,
  output logic [$clog2(MAX_SPINS)-1:0]           spin_addr_o,
  output logic                                   spin_wdata_o,
  input  logic                                   spin_rdata_i,
  output logic [$clog2(MAX_SPINS*MAX_NEIGH)-1:0] neigh_addr_o,
  output logic [igu_pkg::IDX_W-1:0]              neigh_wdata_o,
  input  logic [igu_pkg::IDX_W-1:0]              neigh_rdata_i,
  output logic [$clog2(MAX_SPINS)-1:0]           count_addr_o,
  output logic [igu_pkg::CNT_W-1:0]              count_wdata_o,
  input  logic [igu_pkg::CNT_W-1:0]              count_rdata_i,
  output logic [$clog2(2*MAX_NEIGH+1)-1:0]       tbl_addr_o,
  output logic [igu_pkg::PROB_W-1:0]             tbl_wdata_o,
  input  logic [igu_pkg::PROB_W-1:0]             tbl_rdata_i
);
  import igu_pkg::*;

  localparam int unsigned SW    = $clog2(MAX_SPINS);
  localparam int unsigned AW    = $clog2(MAX_SPINS * MAX_NEIGH);
  localparam int unsigned TL    = 2 * MAX_NEIGH + 1;
  localparam int unsigned TW    = $clog2(TL);
  localparam int unsigned NCW   = $clog2(MAX_NEIGH + 1);
  localparam int unsigned SUM_W = NCW + 1;
  localparam int unsigned IXW   = ((SUM_W > MAXN_W + 1) ? SUM_W : MAXN_W + 1) + 1;

  localparam logic [PIDX_W:0]          TL_V   = (PIDX_W + 1)'(TL);
  localparam logic signed [IXW-1:0]    IX_TOP = IXW'(TL - 1);
  localparam logic signed [SUM_W-1:0]  ONE    = SUM_W'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SITE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_UCNT   = 4'd4;
  localparam logic [3:0] S_ULOOP  = 4'd5;
  localparam logic [3:0] S_UTAB   = 4'd6;
  localparam logic [3:0] S_UFLIP  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  // Item fields held for the whole item.
  kind_e             kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [IDX_W-1:0]  nidx_q;
  logic [CNT_W-1:0]  ncnt_q;
  logic              sval_q;
  logic [PIDX_W-1:0] pidx_q;
  logic [PROB_W-1:0] prob_q;
  logic [PROB_W-1:0] rnd_q;

  logic [SW-1:0]            site_q, site_d;
  logic [AW-1:0]            base_q, base_d;
  logic [NCW-1:0]           cnt_q, cnt_d;
  logic [NCW-1:0]           iss_q, iss_d;
  logic [NCW-1:0]           acc_q, acc_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     own_q, own_d;
  logic                     nb_vld_q, nb_vld_d;
  logic                     sp_vld_q, sp_vld_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic                     res_spin_q, res_spin_d;
  logic                     res_flip_q, res_flip_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_spin_q;
  logic                     out_flip_q;
  logic [TOTAL_W-1:0]       out_total_q;
  logic                     out_load;

  logic                     accept;
  logic                     flip;
  logic signed [SUM_W-1:0]  own_sum;
  logic signed [IXW-1:0]    ix_raw;
  logic [TW-1:0]            tidx;

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && (state_q == S_IDLE);
  assign flip         = rnd_q < tbl_rdata_i;

  // Table index: local field sum seen from the chosen spin, offset and clamped.
  assign own_sum = own_q ? sum_q : -sum_q;
  assign ix_raw  = IXW'(own_sum) + IXW'(signed'({1'b0, max_neighbours_i}));

  always_comb begin
    if (ix_raw < 0) begin
      tidx = '0;
    end else if (ix_raw > IX_TOP) begin
      tidx = TW'(TL - 1);
    end else begin
      tidx = TW'(ix_raw);
    end
  end

  always_comb begin
    state_d     = state_q;
    site_d      = site_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    own_d       = own_q;
    nb_vld_d    = 1'b0;
    sp_vld_d    = 1'b0;
    total_d     = total_q;
    res_spin_d  = res_spin_q;
    res_flip_d  = res_flip_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_load    = 1'b0;

    cmd_o         = '0;
    red_valid_o   = 1'b0;
    red_value_o   = neigh_rdata_i;
    spin_addr_o   = site_q;
    spin_wdata_o  = sval_q;
    neigh_addr_o  = base_q + AW'(iss_q);
    neigh_wdata_o = nidx_q;
    count_addr_o  = site_q;
    count_wdata_o = ncnt_q;
    tbl_addr_o    = tidx;
    tbl_wdata_o   = prob_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          red_valid_o = 1'b1;
          red_value_o = item_i.spin_index;
          state_d     = S_SITE;
        end
      end
      S_SITE: begin
        if (red_valid_i) begin
          site_d  = SW'(red_value_i);
          base_d  = AW'(site_d * MAX_NEIGH);
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        iss_d      = '0;
        acc_d      = '0;
        sum_d      = '0;
        res_flip_d = 1'b0;
        unique case (kind_q)
          KIND_LOAD_SPIN: begin
            cmd_o.spin.wr = 1'b1;
            res_spin_d    = sval_q;
            state_d       = S_OUT;
          end
          KIND_LOAD_NEIGH: begin
            cmd_o.neigh.wr = int'(slot_q) < MAX_NEIGH;
            neigh_addr_o   = base_q + AW'(slot_q);
            cmd_o.spin.rd  = 1'b1;
            state_d        = S_RDWAIT;
          end
          KIND_LOAD_COUNT: begin
            cmd_o.count.wr = 1'b1;
            cmd_o.spin.rd  = 1'b1;
            state_d        = S_RDWAIT;
          end
          KIND_LOAD_TABLE: begin
            cmd_o.tbl.wr  = {1'b0, pidx_q} < TL_V;
            tbl_addr_o    = TW'(pidx_q);
            cmd_o.spin.rd = 1'b1;
            state_d       = S_RDWAIT;
          end
          KIND_UPDATE: begin
            cmd_o.count.rd = 1'b1;
            cmd_o.spin.rd  = 1'b1;
            state_d        = S_UCNT;
          end
          KIND_CLEAR_COUNT: begin
            total_d       = '0;
            cmd_o.spin.rd = 1'b1;
            state_d       = S_RDWAIT;
          end
          default: begin
            cmd_o.spin.rd = 1'b1;
            state_d       = S_RDWAIT;
          end
        endcase
      end
      S_RDWAIT: begin
        res_spin_d = spin_rdata_i;
        state_d    = S_OUT;
      end
      S_UCNT: begin
        if (int'(count_rdata_i) > MAX_NEIGH) begin
          cnt_d = NCW'(MAX_NEIGH);
        end else begin
          cnt_d = NCW'(count_rdata_i);
        end
        own_d   = spin_rdata_i;
        state_d = S_ULOOP;
      end
      S_ULOOP: begin
        // Three overlapping steps: list read, index reduction, neighbour spin read.
        if (iss_q != cnt_q) begin
          cmd_o.neigh.rd = 1'b1;
          iss_d          = iss_q + NCW'(1);
          nb_vld_d       = 1'b1;
        end
        red_valid_o = nb_vld_q;
        if (red_valid_i) begin
          cmd_o.spin.rd = 1'b1;
          spin_addr_o   = SW'(red_value_i);
          sp_vld_d      = 1'b1;
        end
        if (sp_vld_q) begin
          sum_d = sum_q + (spin_rdata_i ? ONE : -ONE);
          acc_d = acc_q + NCW'(1);
        end
        if (acc_q == cnt_q) begin
          state_d = S_UTAB;
        end
      end
      S_UTAB: begin
        cmd_o.tbl.rd = 1'b1;
        state_d      = S_UFLIP;
      end
      S_UFLIP: begin
        if (flip) begin
          cmd_o.spin.wr = 1'b1;
          spin_wdata_o  = !own_q;
          if (total_q != {TOTAL_W{1'b1}}) begin
            total_d = total_q + TOTAL_W'(1);
          end
        end
        res_spin_d = own_q ^ flip;
        res_flip_d = flip;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nb_vld_q    <= 1'b0;
      sp_vld_q    <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_vld_q    <= nb_vld_d;
      sp_vld_q    <= sp_vld_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(item_i.kind);
      slot_q <= item_i.neigh_slot;
      nidx_q <= item_i.neighbour_index;
      ncnt_q <= item_i.neighbour_count;
      sval_q <= item_i.spin_value;
      pidx_q <= item_i.prob_index;
      prob_q <= item_i.accept_prob;
      rnd_q  <= item_i.random_fraction;
    end
    site_q     <= site_d;
    base_q     <= base_d;
    cnt_q      <= cnt_d;
    iss_q      <= iss_d;
    acc_q      <= acc_d;
    sum_q      <= sum_d;
    own_q      <= own_d;
    res_spin_q <= res_spin_d;
    res_flip_q <= res_flip_d;
    if (out_load) begin
      out_spin_q  <= res_spin_q;
      out_flip_q  <= res_flip_q;
      out_total_q <= total_q;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.spin_state     = out_spin_q;
  assign result_o.flipped        = out_flip_q;
  assign result_o.accepted_total = out_total_q;

endmodule

// ===== sv/ising_glauber_spin_update.sv =====
// Ising lattice with single-spin Glauber updates; one item in work at a time.
// A new item is taken only after the last one has loaded its result into the output register;
// the neighbour walk sets the update time. Reset clears the sequencer and the accept count and
// sets max_neighbours to 4; memories are undefined until loaded.
module ising_glauber_spin_update #(
  parameter int unsigned MAX_SPINS = 4096,
  parameter int unsigned MAX_NEIGH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [igu_pkg::PADDR_W-1:0]   paddr,
  input  logic [igu_pkg::PDATA_W-1:0]   pwdata,
  output logic [igu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  igu_item_if.sink                      item_i,
  igu_result_if.source                  result_o
);
  import igu_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SPINS);
  localparam int unsigned AW = $clog2(MAX_SPINS * MAX_NEIGH);
  localparam int unsigned TW = $clog2(2 * MAX_NEIGH + 1);

  // The only register: the offset added to the signed neighbour sum. It is
  // written on the access phase of an APB write to its word address.
  logic [MAXN_W-1:0] maxn_q;
  logic              reg_hit;

  assign reg_hit = paddr[PADDR_W-1:2] == REG_MAX_NEIGH;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(maxn_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxn_q <= MAXN_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      maxn_q <= pwdata[MAXN_W-1:0];
    end
  end

  // Wiring between the sequencer, the index reduction pipeline and the memories.
  logic              red_in_valid;
  logic [IDX_W-1:0]  red_in_value;
  logic              red_out_valid;
  logic [IDX_W-1:0]  red_out_value;
  store_cmd_t        cmd;
  logic [SW-1:0]     spin_addr;
  logic              spin_wdata;
  logic              spin_rdata;
  logic [AW-1:0]     neigh_addr;
  logic [IDX_W-1:0]  neigh_wdata;
  logic [IDX_W-1:0]  neigh_rdata;
  logic [SW-1:0]     count_addr;
  logic [CNT_W-1:0]  count_wdata;
  logic [CNT_W-1:0]  count_rdata;
  logic [TW-1:0]     tbl_addr;
  logic [PROB_W-1:0] tbl_wdata;
  logic [PROB_W-1:0] tbl_rdata;

  // The sequencer accepts a transfer only when idle; the finished result sits
  // in its output register, so the next transfer is taken while it waits.
  igu_ctrl #(
    .MAX_SPINS (MAX_SPINS),
    .MAX_NEIGH (MAX_NEIGH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .max_neighbours_i (maxn_q),
    .item_i           (item_i),
    .result_o         (result_o),
    .red_valid_o      (red_in_valid),
    .red_value_o      (red_in_value),
    .red_valid_i      (red_out_valid),
    .red_value_i      (red_out_value),
    .cmd_o            (cmd),
    .spin_addr_o      (spin_addr),
    .spin_wdata_o     (spin_wdata),
    .spin_rdata_i     (spin_rdata),
    .neigh_addr_o     (neigh_addr),
    .neigh_wdata_o    (neigh_wdata),
    .neigh_rdata_i    (neigh_rdata),
    .count_addr_o     (count_addr),
    .count_wdata_o    (count_wdata),
    .count_rdata_i    (count_rdata),
    .tbl_addr_o       (tbl_addr),
    .tbl_wdata_o      (tbl_wdata),
    .tbl_rdata_i      (tbl_rdata)
  );

  // Lattice indices, both the requested one and those read from the neighbour
  // list, are folded into the lattice by this pipeline.
  igu_modred #(
    .MAX_SPINS (MAX_SPINS)
  ) u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (red_in_valid),
    .value_i (red_in_value),
    .valid_o (red_out_valid),
    .value_o (red_out_value)
  );

  igu_store #(
    .MAX_SPINS (MAX_SPINS),
    .MAX_NEIGH (MAX_NEIGH)
  ) u_store (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .spin_addr_i   (spin_addr),
    .spin_wdata_i  (spin_wdata),
    .spin_rdata_o  (spin_rdata),
    .neigh_addr_i  (neigh_addr),
    .neigh_wdata_i (neigh_wdata),
    .neigh_rdata_o (neigh_rdata),
    .count_addr_i  (count_addr),
    .count_wdata_i (count_wdata),
    .count_rdata_o (count_rdata),
    .tbl_addr_i    (tbl_addr),
    .tbl_wdata_i   (tbl_wdata),
    .tbl_rdata_o   (tbl_rdata)
  );

endmodule

// ===== sv/igu_checker.sv =====
// Port-level checks for the spin update block, attached to the top level by bind.
// Depends on igu_pkg for the result width.
module igu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_spin_i,
  input logic                        out_flip_i,
  input logic [igu_pkg::TOTAL_W-1:0] out_total_i
);
  import igu_pkg::*;

  logic [1:0] pend_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_quiet_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_spin_i) &&
    $stable(out_flip_i) && $stable(out_total_i))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_i)
    else $error("item taken while one is in work and one waits");

  a_flip_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_flip_i |-> out_total_i != '0)
    else $error("flip reported with zero accept count");

endmodule

bind ising_glauber_spin_update igu_checker u_igu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_spin_i  (result_o.spin_state),
  .out_flip_i  (result_o.flipped),
  .out_total_i (result_o.accepted_total)
);
